// ===== hdl/sprite_rle_decoder_defines.svh =====
// Assertion macros for the sprite run-length decoder.
// Used by the top level; relies on clk and rst_n in the including module.
`ifndef SPRITE_RLE_DECODER_DEFINES_SVH
`define SPRITE_RLE_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/srd_pkg.sv =====
// Shared types and constants for the sprite run-length decoder.
// No dependencies.
`timescale 1ns / 1ps

package srd_pkg;

    localparam int COORD_BITS = 16;

    // Decode modes
    localparam logic [2:0] MODE_OP      = 3'd0;
    localparam logic [2:0] MODE_LITERAL = 3'd1;
    localparam logic [2:0] MODE_SHADOW1 = 3'd2;
    localparam logic [2:0] MODE_SHADOW2 = 3'd3;
    localparam logic [2:0] MODE_COUNT   = 3'd4;
    localparam logic [2:0] MODE_COLOR   = 3'd5;

    // Opcode values
    localparam logic [7:0] OP_LINE_END  = 8'h00;
    localparam logic [7:0] OP_IMAGE_END = 8'h80;
    localparam logic [7:0] OP_SHADOW    = 8'hC0;
    localparam logic [7:0] OP_COUNT     = 8'hC1;

    typedef struct packed {
        logic [2:0]            mode;
        logic [7:0]            remaining;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic                  finished;
    } state_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  run_length;
        logic [7:0]  color_index;
        logic        is_shadow;
        logic        image_end;
    } result_t;

    localparam state_t STATE_RESET = '{
        mode:      MODE_OP,
        remaining: 8'd0,
        cur_x:     '0,
        cur_y:     '0,
        finished:  1'b0
    };

endpackage

// ===== hdl/sprite_rle_decoder.sv =====
// Top level of the sprite run-length decoder: input register, decode step, result register.
// Depends on srd_pkg, srd_decode, srd_out_reg and sprite_rle_decoder_defines.svh.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_stall | code_byte, last_byte
//  out     | out_valid/out_stall | pos_x, pos_y, run_length, color_index,
//          |                     | is_shadow, image_end
//
// One byte per cycle sustained while the result register is not stalled; a taken byte is
// loaded into the input register, and the decode step then fills the result register.
// Reset clears the decode state and both valid bits; the payload registers are not reset.
// A result-producing byte waits in the input register only while the result register is
// full and stalled; bytes that give no result always pass straight through.
// A last byte returns the decode state to its reset value for the next sprite.
`timescale 1ns / 1ps

`include "sprite_rle_decoder_defines.svh"

module sprite_rle_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  code_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [7:0]  run_length,
    output logic [7:0]  color_index,
    output logic        is_shadow,
    output logic        image_end
);
    import srd_pkg::*;

    // Input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] code_reg;
    logic       last_reg;

    // Decode state
    state_t state_reg;
    state_t state_next;
    state_t dec_state;

    result_t dec_result;
    result_t out_data;
    logic    dec_has_result;
    logic    out_ready;
    logic    dec_fire;
    logic    in_accept;

    srd_decode u_decode (
        .state      (state_reg),
        .code       (code_reg),
        .last       (last_reg),
        .state_next (dec_state),
        .result     (dec_result),
        .has_result (dec_has_result)
    );

    // The held byte is consumed once its result, if any, has somewhere to go.
    assign dec_fire  = in_valid_reg && (!dec_has_result || out_ready);
    assign in_stall  = in_valid_reg && !dec_fire;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next = in_accept || (in_valid_reg && !dec_fire);
    assign state_next    = dec_fire ? dec_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            code_reg <= code_byte;
            last_reg <= last_byte;
        end
    end

    srd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (dec_fire && dec_has_result),
        .load_data (dec_result),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign pos_x       = out_data.pos_x;
    assign pos_y       = out_data.pos_y;
    assign run_length  = out_data.run_length;
    assign color_index = out_data.color_index;
    assign is_shadow   = out_data.is_shadow;
    assign image_end   = out_data.image_end;

    // After the end code only the opcode mode is possible.
    `SRD_ASSERT_NOW(a_finished_mode, state_reg.finished, state_reg.mode == MODE_OP,
        "finished with operands pending")
    // Literal mode always has bytes left to take.
    `SRD_ASSERT_NOW(a_literal_count, state_reg.mode == MODE_LITERAL,
        state_reg.remaining != 8'd0, "literal mode with zero count")
    // A result never overwrites one that is still stalled.
    `SRD_ASSERT_NOW(a_no_overwrite, dec_fire && dec_has_result,
        !(out_valid && out_stall), "result register overwritten while stalled")
    // A decoded last byte leaves the block in its reset state.
    `SRD_ASSERT_NEXT(a_last_resets, dec_fire && last_reg, state_reg == STATE_RESET,
        "state not cleared after last byte")

endmodule

// ===== hdl/srd_decode.sv =====
// One-byte decode step: next state and optional result (a run or an image end).
// Depends on srd_pkg.
`timescale 1ns / 1ps

module srd_decode (
    input  srd_pkg::state_t  state,
    input  logic [7:0]       code,
    input  logic             last,
    output srd_pkg::state_t  state_next,
    output srd_pkg::result_t result,
    output logic             has_result
);
    import srd_pkg::*;

    state_t  ns;
    result_t res;
    logic    emit;
    logic [7:0] run_len;

    always_comb
    begin
        ns      = state;
        emit    = 1'b0;
        run_len = 8'd0;
        res     = '0;
        res.pos_x = 16'(state.cur_x);
        res.pos_y = 16'(state.cur_y);

        if (!state.finished)
        begin
            unique case (state.mode)
                MODE_LITERAL:
                begin
                    emit            = 1'b1;
                    run_len         = 8'd1;
                    res.color_index = code;
                    ns.remaining    = state.remaining - 8'd1;
                    if (state.remaining == 8'd1)
                        ns.mode = MODE_OP;
                end
                MODE_SHADOW1:
                begin
                    if (code[1:0] != 2'd0)
                    begin
                        emit          = 1'b1;
                        run_len       = {6'd0, code[1:0]};
                        res.is_shadow = 1'b1;
                        ns.mode       = MODE_OP;
                    end
                    else
                        ns.mode = MODE_SHADOW2;
                end
                MODE_SHADOW2:
                begin
                    if (code != 8'd0)
                    begin
                        emit          = 1'b1;
                        run_len       = code;
                        res.is_shadow = 1'b1;
                    end
                    ns.mode = MODE_OP;
                end
                MODE_COUNT:
                begin
                    ns.remaining = code;
                    ns.mode      = MODE_COLOR;
                end
                MODE_COLOR:
                begin
                    if (state.remaining != 8'd0)
                    begin
                        emit            = 1'b1;
                        run_len         = state.remaining;
                        res.color_index = code;
                    end
                    ns.remaining = 8'd0;
                    ns.mode      = MODE_OP;
                end
                default:
                begin
                    priority if (code == OP_LINE_END)
                    begin
                        ns.cur_y = state.cur_y + COORD_BITS'(1);
                        ns.cur_x = '0;
                    end
                    else if (code < OP_IMAGE_END)
                    begin
                        ns.remaining = code;
                        ns.mode      = MODE_LITERAL;
                    end
                    else if (code == OP_IMAGE_END)
                    begin
                        emit          = 1'b1;
                        res.image_end = 1'b1;
                        ns.finished   = 1'b1;
                    end
                    else if (code < OP_SHADOW)
                        ns.cur_x = state.cur_x + COORD_BITS'(code[6:0]);
                    else if (code == OP_SHADOW)
                        ns.mode = MODE_SHADOW1;
                    else if (code == OP_COUNT)
                        ns.mode = MODE_COUNT;
                    else
                    begin
                        ns.remaining = {2'd0, code[5:0]};
                        ns.mode      = MODE_COLOR;
                    end
                end
            endcase
            // a pixel run advances the column
            ns.cur_x = ns.cur_x + COORD_BITS'(run_len);
        end
        res.run_length = run_len;

        if (last)
        begin
            if (!state.finished && !emit)
            begin
                // empty end marker at the position after this byte
                res       = '0;
                res.pos_x = 16'(ns.cur_x);
                res.pos_y = 16'(ns.cur_y);
            end
            res.image_end = 1'b1;
            emit          = !state.finished || emit;
            ns            = STATE_RESET;
        end
    end

    assign state_next = ns;
    assign result     = res;
    assign has_result = emit;

endmodule

// ===== hdl/srd_out_reg.sv =====
// Result register with valid/stall handshake towards the consumer.
// Depends on srd_pkg.
`timescale 1ns / 1ps

module srd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  srd_pkg::result_t load_data,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_stall,
    output srd_pkg::result_t out_data
);
    import srd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // free when empty or being drained this cycle
    assign ready      = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
